FILE: src/ljpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ljpf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAG_W = 62;
  localparam logic [MAG_W-1:0] CAP = '1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CUT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0]      atom_a;
    logic [15:0]      atom_b;
    logic [2:0][31:0] dm;
    logic [2:0]       dn;
    logic [31:0]      sm;
    logic             sneg;
    logic [31:0]      sig;
    logic [31:0]      cut;
    status_t          status;
    logic [MAG_W-1:0] s;
    logic             dneg;
  } side_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // saturate a magnitude into a signed 32 bit word
  function automatic logic [31:0] pack32(input logic [MAG_W-1:0] mag, input logic neg);
    logic [31:0] m;
    if (neg) begin
      m = (mag > MAG_W'(33'h080000000)) ? 32'h80000000 : mag[31:0];
      return ~m + 32'd1;
    end
    return (mag > MAG_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : mag[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/ljpf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module ljpf_mul #(
  parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [63:0]                  a,
  input  wire logic [63:0]                  b,
  output logic      [ljpf_pkg::MAG_W-1:0]   p
);
  import ljpf_pkg::*;

  logic [63:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic [127:0] sum;
  logic [127:0] shr;

  assign shr = sum >> FRAC_BITS;

  // three stages: partial products, wide sum, shift and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= 64'(a[31:0]) * 64'(b[31:0]);
      pp_lh <= 64'(a[31:0]) * 64'(b[63:32]);
      pp_hl <= 64'(a[63:32]) * 64'(b[31:0]);
      pp_hh <= 64'(a[63:32]) * 64'(b[63:32]);
      sum   <= {64'd0, pp_ll} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
             + {pp_hh, 64'd0};
      p     <= (|shr[127:MAG_W]) ? CAP : shr[MAG_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/ljpf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ljpf_div #(
  parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [63:0]                 den,
  input  wire logic [31:0]                 num,
  output logic      [32+2*FRAC_BITS-1:0]   quo
);
  import ljpf_pkg::*;

  localparam int NB = 32 + 2 * FRAC_BITS;

  logic [63:0]   rem_r [NB];
  logic [63:0]   den_r [NB];
  logic [31:0]   num_r [NB];
  logic [NB-1:0] q_r   [NB];

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [63:0]   pr, pd;
    logic [31:0]   pn;
    logic [NB-1:0] pq;
    logic [64:0]   t;
    logic          bt, one;
    int            idx;
    if (en) begin
      for (int j = 0; j < NB; j++) begin
        if (j == 0) begin
          pr = '0;
          pd = den;
          pn = num;
          pq = '0;
        end else begin
          pr = rem_r[j-1];
          pd = den_r[j-1];
          pn = num_r[j-1];
          pq = q_r[j-1];
        end
        idx = NB - 1 - j - 2 * FRAC_BITS;
        bt  = (idx >= 0) ? pn[idx[4:0]] : 1'b0;
        t   = {pr, bt};
        one = (t >= {1'b0, pd});
        rem_r[j] <= one ? 64'(t - {1'b0, pd}) : t[63:0];
        den_r[j] <= pd;
        num_r[j] <= pn;
        q_r[j]   <= {pq[NB-2:0], one};
      end
    end
  end

  assign quo = q_r[NB-1];

endmodule
`default_nettype wire

FILE: src/lj_pair_force.sv
// throughput: one pair per cycle unless the spare output entry is full, which stalls
// the pipeline; the quotient is built one bit per stage and each product goes through
// a three stage 32x32 partial product multiplier
// a two entry output buffer lets the pipeline run while a result waits
// rst (synchronous) clears valid bits and the output buffer; data is not cleared
`timescale 1ns / 1ps
`default_nettype none
module lj_pair_force #(
  parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // first_atom, second_atom, dx, dy, dz, sigma_sq, cutoff_sq, strength
  input  wire logic [223:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // atom_a, atom_b, force_x, force_y, force_z
  output logic      [127:0] m_tdata,
  // status
  output logic      [1:0]   m_tuser
);
  import ljpf_pkg::*;

  localparam int NB   = 32 + 2 * FRAC_BITS;
  localparam int ST_S = 4 + NB;
  localparam int LAST = ST_S + 16;

  side_t            sb  [1:LAST];
  logic             vld [1:LAST];
  logic [63:0]      sq  [3];
  logic [63:0]      r2;
  logic [63:0]      r2_sum;
  logic [NB-1:0]    quo;
  logic [127:0]     q_ext;
  logic [MAG_W-1:0] s2, s3, s4, om, s4_q, diff, g;
  logic [MAG_W-1:0] fm  [3];
  logic [MAG_W-1:0] one;
  logic             en, gneg;
  logic [127:0]     res_data;
  logic [1:0]       res_user;
  logic             spare_vld;
  logic [127:0]     spare_data;
  logic [1:0]       spare_user;

  assign en       = ~spare_vld;
  assign s_tready = en;
  assign r2_sum   = sq[0] + sq[1] + sq[2];
  assign q_ext    = 128'(quo);
  assign one      = MAG_W'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAST; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= LAST; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_t st_cut, st_s, st_dn;
    if (en) begin
      sb[1].atom_a <= s_tdata[15:0];
      sb[1].atom_b <= s_tdata[31:16];
      sb[1].dm[0]  <= mag32(s_tdata[63:32]);
      sb[1].dm[1]  <= mag32(s_tdata[95:64]);
      sb[1].dm[2]  <= mag32(s_tdata[127:96]);
      sb[1].dn     <= {s_tdata[127], s_tdata[95], s_tdata[63]};
      sb[1].sig    <= s_tdata[159:128];
      sb[1].cut    <= s_tdata[191:160];
      sb[1].sm     <= mag32(s_tdata[223:192]);
      sb[1].sneg   <= s_tdata[223];
      sb[1].status <= ST_OK;
      sb[1].s      <= '0;
      sb[1].dneg   <= 1'b0;
      for (int i = 0; i < 3; i++) sq[i] <= 64'(sb[1].dm[i]) * 64'(sb[1].dm[i]);
      // squared distance, cutoff test
      r2 <= r2_sum;
      st_cut = sb[2];
      if (r2_sum == 64'd0) begin
        st_cut.status = ST_ZERO;
      end else if (r2_sum > (64'(sb[2].cut) << FRAC_BITS)) begin
        st_cut.status = ST_CUT;
      end else begin
        st_cut.status = ST_OK;
      end
      st_s   = sb[ST_S-1];
      st_s.s = (|q_ext[127:MAG_W]) ? CAP : q_ext[MAG_W-1:0];
      // s^3 - 1 as magnitude and sign
      s4_q  <= s4;
      st_dn = sb[ST_S+6];
      if (s3 >= one) begin
        om <= s3 - one;
        st_dn.dneg = 1'b0;
      end else begin
        om <= one - s3;
        st_dn.dneg = 1'b1;
      end
      for (int k = 2; k <= LAST; k++) begin
        if (k == 3) begin
          sb[k] <= st_cut;
        end else if (k == ST_S) begin
          sb[k] <= st_s;
        end else if (k == ST_S + 7) begin
          sb[k] <= st_dn;
        end else begin
          sb[k] <= sb[k-1];
        end
      end
    end
  end

  ljpf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .den(r2), .num(sb[3].sig), .quo(quo)
  );

  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_s2 (
    .clk(clk), .en(en), .a(64'(sb[ST_S].s)), .b(64'(sb[ST_S].s)), .p(s2)
  );
  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_s3 (
    .clk(clk), .en(en), .a(64'(s2)), .b(64'(sb[ST_S+3].s)), .p(s3)
  );
  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_s4 (
    .clk(clk), .en(en), .a(64'(s2)), .b(64'(s2)), .p(s4)
  );
  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_diff (
    .clk(clk), .en(en), .a(64'(s4_q)), .b(64'(om)), .p(diff)
  );
  ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_g (
    .clk(clk), .en(en), .a(64'(sb[ST_S+10].sm)), .b(64'(diff)), .p(g)
  );

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ljpf_mul #(.FRAC_BITS(FRAC_BITS)) u_f (
      .clk(clk), .en(en), .a(64'(g)), .b(64'(sb[ST_S+13].dm[i])), .p(fm[i])
    );
  end

  assign gneg = sb[LAST].sneg ^ sb[LAST].dneg;

  always_comb begin
    res_data[15:0]  = sb[LAST].atom_a;
    res_data[31:16] = sb[LAST].atom_b;
    for (int i = 0; i < 3; i++) begin
      res_data[32*i+32 +: 32] = (sb[LAST].status == ST_OK)
                              ? pack32(fm[i], gneg ^ sb[LAST].dn[i]) : 32'd0;
    end
    res_user = sb[LAST].status;
  end

  // output register plus spare entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      spare_vld <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && spare_vld) begin
        m_tdata   <= spare_data;
        m_tuser   <= spare_user;
        spare_vld <= 1'b0;
      end else if (en && vld[LAST] && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_data;
        m_tuser  <= res_user;
      end else if (en && vld[LAST]) begin
        spare_vld  <= 1'b1;
        spare_data <= res_data;
        spare_user <= res_user;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/ljpf_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ljpf_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata,
  input wire logic [1:0]   m_tuser
);
  import ljpf_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled transfer changed");

  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[127:32] == 96'd0)
    else $error("nonzero force outside range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind lj_pair_force ljpf_chk u_chk (.*);
`default_nettype wire
